// ===== rtl/core/pidl_pkg.sv =====
package pidl_pkg;

   localparam int DEPTH  = 128;
   localparam int DATA_W = 32;
   localparam int POS_W  = 8;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // wide enough for both the position field and the true count
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GRP    = 8;
   localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CMP_W-1:0]         idx_type;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GATHER
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE
   } cell_op_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [POS_W-1:0] position;
      data_type         item;
   } req_item_type;

   typedef struct packed {
      data_type   data;
      logic [1:0] status;
      logic [7:0] count;
      logic       empty_res;
      logic       full_res;
   } rsp_item_type;

   typedef struct packed {
      cell_op_type op;
      idx_type     pos;
      data_type    item;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/pidl_cell.sv =====
module pidl_cell (
   input  logic                   clock,
   input  pidl_pkg::cell_ctrl_type ctrl,
   input  pidl_pkg::idx_type      idx,
   input  pidl_pkg::data_type     prev_entry,
   input  pidl_pkg::data_type     next_entry,
   output pidl_pkg::data_type     entry,
   output pidl_pkg::data_type     tap
);
   import pidl_pkg::*;

   data_type entry_ff;
   data_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_INSERT: begin
            if (idx > ctrl.pos) begin
               entry_in = prev_entry;
            end else if (idx == ctrl.pos) begin
               entry_in = ctrl.item;
            end
         end
         OP_DELETE: begin
            if (idx >= ctrl.pos) begin
               entry_in = next_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // only the addressed cell drives its word onto the read tree
   assign tap   = (idx == ctrl.pos) ? entry_ff : '0;

endmodule

// ===== rtl/core/pidl_read_tree.sv =====
module pidl_read_tree (
   input  logic                                   clock,
   input  logic                                   capture,
   input  pidl_pkg::data_type [pidl_pkg::DEPTH-1:0] taps,
   output pidl_pkg::data_type                     read_data
);
   import pidl_pkg::*;

   data_type [NGRP-1:0] group_ff;
   data_type [NGRP-1:0] group_in;

   always_comb begin
      group_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < DEPTH) begin
               group_in[g] = group_in[g] | taps[g * GRP + k];
            end
         end
      end
   end

   // hold the captured words so a stalled result keeps the pre-shift value
   always_ff @(posedge clock) begin
      if (capture) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      read_data = '0;
      for (int g = 0; g < NGRP; g++) begin
         read_data = read_data | group_ff[g];
      end
   end

endmodule

// ===== rtl/core/positional_insert_delete_list.sv =====
// channel | ports                                   | direction
// req     | req_valid, req_ready, req_payload       | in
// rsp     | rsp_valid, rsp_ready, rsp_payload       | out
//
// three steps per item: accept, shift the cell chain, collect the read tree.
// the collect step waits while the output register still holds an untaken item.
// the cell chain does an insert or delete in one step; a read goes through a
// two-level registered or-tree. reset clears the count and the handshake state.
module positional_insert_delete_list (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pidl_pkg::req_item_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pidl_pkg::rsp_item_type rsp_payload
);
   import pidl_pkg::*;

   state_type     state_ff, state_in;
   req_item_type  req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type    stat_ff, stat_in;
   logic          use_data_ff, use_data_in;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;
   logic          rsp_load;
   logic          exec_en;
   logic          is_full;
   idx_type       pos_ext;
   idx_type       cnt_ext;
   cell_ctrl_type ctrl;
   cell_op_type   op_sel;
   idx_type       op_pos;
   data_type [DEPTH-1:0] entries;
   data_type [DEPTH-1:0] taps;
   data_type      read_data;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EXEC;
         S_EXEC:   state_in = S_GATHER;
         S_GATHER: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      exec_en   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_ready = 1'b1;
         S_EXEC:   exec_en   = 1'b1;
         S_GATHER: rsp_load  = !rsp_valid_ff || rsp_ready;
         default:  req_ready = 1'b0;
      endcase
   end

   assign pos_ext = CMP_W'(req_ff.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign is_full = count_ff >= CNT_W'(DEPTH);

   always_comb begin
      op_sel      = OP_HOLD;
      op_pos      = pos_ext;
      count_in    = count_ff;
      stat_in     = STAT_DONE;
      use_data_in = 1'b0;
      unique case (req_code_type'(req_ff.req_type))
         REQ_INSERT: begin
            if (is_full) begin
               stat_in = STAT_FULL;
            end else if (pos_ext > cnt_ext) begin
               stat_in = STAT_RANGE;
            end else begin
               op_sel   = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_APPEND: begin
            op_pos = cnt_ext;
            if (is_full) begin
               stat_in = STAT_FULL;
            end else begin
               op_sel   = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               stat_in = STAT_RANGE;
            end else begin
               op_sel      = OP_DELETE;
               use_data_in = 1'b1;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (pos_ext >= cnt_ext) begin
               stat_in = STAT_RANGE;
            end else begin
               use_data_in = 1'b1;
            end
         end
      endcase
   end

   assign ctrl.op   = exec_en ? op_sel : OP_HOLD;
   assign ctrl.pos  = op_pos;
   assign ctrl.item = req_ff.item;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type prev_w;
      data_type next_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid
         assign prev_w = entries[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_body
         assign next_w = entries[i+1];
      end
      pidl_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (CMP_W'(i)),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .entry      (entries[i]),
         .tap        (taps[i])
      );
   end

   // tree samples the pre-shift words at the end of the exec cycle
   pidl_read_tree u_read_tree (
      .clock     (clock),
      .capture   (exec_en),
      .taps      (taps),
      .read_data (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_en) begin
            count_ff <= count_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (exec_en) begin
         stat_ff     <= stat_in;
         use_data_ff <= use_data_in;
      end
      if (rsp_load) begin
         rsp_ff.data      <= use_data_ff ? read_data : '0;
         rsp_ff.status    <= stat_ff;
         rsp_ff.count     <= count_ff[7:0];
         rsp_ff.empty_res <= (count_ff == '0);
         rsp_ff.full_res  <= (count_ff == CNT_W'(DEPTH));
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_count_only_exec: assert property (@(posedge clock)
      (!reset && state_ff != S_EXEC) |=> (reset || count_ff == $past(count_ff)))
      else $error("entry count changed outside exec");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STAT_FULL) |-> rsp_payload.full_res)
      else $error("full status without full flag");

endmodule
